// File: rtl/tia_pkg.sv
// shared types, codes and constants for the typed integer alu
package tia_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned DivCells = 32;

  typedef enum logic [3:0] {
    FN_ADD = 4'd0, FN_SUB = 4'd1, FN_MUL = 4'd2, FN_DIV = 4'd3, FN_MOD = 4'd4,
    FN_LT = 4'd5, FN_LE = 4'd6, FN_GT = 4'd7, FN_GE = 4'd8, FN_EQ = 4'd9,
    FN_NE = 4'd10, FN_AND = 4'd11, FN_OR = 4'd12, FN_XOR = 4'd13, FN_CAST = 4'd14,
    FN_NONE = 4'd15
  } func_t;

  typedef enum logic [1:0] {
    TY_SHORT = 2'd0, TY_INT = 2'd1, TY_LONG = 2'd2, TY_BOOL = 2'd3
  } vtype_t;

  typedef enum logic [2:0] {
    ER_OK = 3'd0, ER_BOOL_ARITH = 3'd1, ER_DIV_ZERO = 3'd2, ER_BOOL_ORDER = 3'd3,
    ER_BOOL_BITWISE = 3'd4, ER_NOT_INT = 3'd5
  } err_t;

  typedef struct packed {
    logic [3:0]        func;
    logic signed [31:0] left_value;
    logic [1:0]        left_type;
    logic signed [31:0] right_value;
    logic [1:0]        right_type;
    logic [1:0]        target_type;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic [1:0]         result_type;
    logic [2:0]         error_code;
  } out_item_t;

  // item context carried along the divider chain
  typedef struct packed {
    logic        valid;
    logic        is_div;     // result comes from the quotient
    logic        is_mod;     // result comes from the remainder
    logic        neg_q;
    logic        neg_r;
    logic        short_res;  // sign-extend from 16 bits at the end
    logic [31:0] value;      // finished value for non-divide items
    logic [1:0]  rtype;
    logic [2:0]  err;
  } ctl_t;

  function automatic logic [31:0] sext16(input logic [31:0] x);
    sext16 = {{16{x[15]}}, x[15:0]};
  endfunction

  function automatic logic [31:0] read_as(input logic [31:0] v, input logic [1:0] t);
    case (t)
      TY_SHORT: read_as = sext16(v);
      TY_BOOL:  read_as = {31'd0, v != 32'd0};
      default:  read_as = v;
    endcase
  endfunction

endpackage

// File: rtl/typed_integer_alu.sv
// top level of the typed integer alu: front end, division chain and output stage
// One item is taken every cycle while in_stall is low; its result passes the
// division cells and the output register. The front end is combinational into
// a chain of 32 restoring-division cells, one quotient bit per cell, and every
// item, not only divides, rides the chain so order is kept. Add, sub, mul,
// compare, bitwise and cast are worked out on entry and carried along. The whole
// chain moves only while the output register can take an item, so a stall on
// the result side holds every item in place and ripples back to in_stall at
// once. Errors force value and type to zero; short results are sign-extended.
module typed_integer_alu (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  tia_pkg::in_item_t in_item,
  output logic              out_valid,
  input  logic              out_stall,
  output tia_pkg::out_item_t out_item
);
  localparam int unsigned W = tia_pkg::DataW;

  tia_pkg::ctl_t ctl [0:W];
  logic [W-1:0] rem [0:W];
  logic [W-1:0] quo [0:W];
  logic [W-1:0] dsr [0:W];
  logic adv;
  tia_pkg::ctl_t tail;
  logic [W-1:0] q_fin, r_fin, v_fin;
  tia_pkg::out_item_t res_nxt;
  logic out_valid_r;
  tia_pkg::out_item_t out_item_r;

  // chain advances whenever the output register is empty or being emptied
  assign adv = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  // front end: everything except the quotient bits
  tia_front u_front (
    .item      (in_item),
    .item_valid(in_valid),
    .ctl       (ctl[0]),
    .mag_a     (quo[0]),
    .mag_b     (dsr[0])
  );
  assign rem[0] = '0;

  // division chain, msb cell first
  for (genvar i = 0; i < W; i++) begin : g_cell
    tia_div_cell #(.W(W)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .adv    (adv),
      .ctl_in (ctl[i]),
      .rem_in (rem[i]),
      .quo_in (quo[i]),
      .dsr_in (dsr[i]),
      .ctl_out(ctl[i+1]),
      .rem_out(rem[i+1]),
      .quo_out(quo[i+1]),
      .dsr_out(dsr[i+1])
    );
  end

  // sign fix-up and result selection at the tail
  always_comb begin
    tail = ctl[W];
    q_fin = tail.neg_q ? '0 - quo[W] : quo[W];
    r_fin = tail.neg_r ? '0 - rem[W] : rem[W];
    if (tail.is_div) v_fin = q_fin;
    else if (tail.is_mod) v_fin = r_fin;
    else v_fin = tail.value;
    if ((tail.is_div || tail.is_mod) && tail.short_res) v_fin = tia_pkg::sext16(v_fin);
    res_nxt.result_value = v_fin;
    res_nxt.result_type = tail.rtype;
    res_nxt.error_code = tail.err;
    if (tail.err != tia_pkg::ER_OK) begin
      res_nxt.result_value = '0;
      res_nxt.result_type = tia_pkg::TY_SHORT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= tail.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_item_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item = out_item_r;

  // errors always come with zeroed value and type
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.error_code != tia_pkg::ER_OK |->
      out_item.result_value == '0 && out_item.result_type == tia_pkg::TY_SHORT)
    else $error("error result not cleared");
  // stalled output holds its item
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("output item changed under stall");
  // input stall follows output stall exactly
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("stall chain mismatch");
  // the divider never sees a zero divisor on a real divide
  a_dsr: assert property (@(posedge clk) disable iff (!rst_n)
    ctl[W].valid && (ctl[W].is_div || ctl[W].is_mod) |-> dsr[W] != '0)
    else $error("zero divisor reached the chain tail");
endmodule

// File: rtl/tia_front.sv
// operand reading, promotion, checks and all operations other than divide and modulo
module tia_front (
  input  tia_pkg::in_item_t item,
  input  logic              item_valid,
  output tia_pkg::ctl_t     ctl,
  output logic [31:0]       mag_a,
  output logic [31:0]       mag_b
);
  logic [31:0] a, b, ua, ub, val, prod;
  logic [1:0] pt, rt;
  logic [2:0] err;
  logic any_bool, slt_ab, slt_ba, c, is_dv, is_md;

  always_comb begin
    a = tia_pkg::read_as(item.left_value, item.left_type);
    b = tia_pkg::read_as(item.right_value, item.right_type);
    if (item.left_type == tia_pkg::TY_LONG || item.right_type == tia_pkg::TY_LONG)
      pt = tia_pkg::TY_LONG;
    else if (item.left_type == tia_pkg::TY_INT || item.right_type == tia_pkg::TY_INT)
      pt = tia_pkg::TY_INT;
    else if (item.left_type == tia_pkg::TY_BOOL && item.right_type == tia_pkg::TY_BOOL)
      pt = tia_pkg::TY_BOOL;
    else
      pt = tia_pkg::TY_SHORT;
    any_bool = item.left_type == tia_pkg::TY_BOOL || item.right_type == tia_pkg::TY_BOOL;
    slt_ab = $signed(a) < $signed(b);
    slt_ba = $signed(b) < $signed(a);
    // only the low word of the product is ever used
    prod = a * b;
    ua = a[31] ? 32'd0 - a : a;
    ub = b[31] ? 32'd0 - b : b;
    val = '0;
    rt = tia_pkg::TY_SHORT;
    err = tia_pkg::ER_OK;
    is_dv = 1'b0;
    is_md = 1'b0;
    c = 1'b0;
    case (tia_pkg::func_t'(item.func))
      tia_pkg::FN_ADD, tia_pkg::FN_SUB, tia_pkg::FN_MUL, tia_pkg::FN_DIV,
      tia_pkg::FN_MOD: begin
        if (any_bool) err = tia_pkg::ER_BOOL_ARITH;
        else if ((item.func == tia_pkg::FN_DIV || item.func == tia_pkg::FN_MOD)
                 && (pt == tia_pkg::TY_SHORT ? tia_pkg::sext16(b) : b) == 32'd0)
          err = tia_pkg::ER_DIV_ZERO;
        else begin
          rt = pt;
          case (tia_pkg::func_t'(item.func))
            tia_pkg::FN_ADD: val = a + b;
            tia_pkg::FN_SUB: val = a - b;
            tia_pkg::FN_MUL: val = prod;
            tia_pkg::FN_DIV: is_dv = 1'b1;
            default:         is_md = 1'b1;
          endcase
          if (pt == tia_pkg::TY_SHORT) val = tia_pkg::sext16(val);
        end
      end
      tia_pkg::FN_LT, tia_pkg::FN_LE, tia_pkg::FN_GT, tia_pkg::FN_GE,
      tia_pkg::FN_EQ, tia_pkg::FN_NE: begin
        if (pt == tia_pkg::TY_BOOL && item.func <= tia_pkg::FN_GE)
          err = tia_pkg::ER_BOOL_ORDER;
        else begin
          case (tia_pkg::func_t'(item.func))
            tia_pkg::FN_LT: c = slt_ab;
            tia_pkg::FN_LE: c = !slt_ba;
            tia_pkg::FN_GT: c = slt_ba;
            tia_pkg::FN_GE: c = !slt_ab;
            tia_pkg::FN_EQ: c = a == b;
            default:        c = a != b;
          endcase
          val = {31'd0, c};
          rt = tia_pkg::TY_INT;
        end
      end
      tia_pkg::FN_AND, tia_pkg::FN_OR, tia_pkg::FN_XOR: begin
        if (any_bool) err = tia_pkg::ER_BOOL_BITWISE;
        else if (pt != tia_pkg::TY_INT) err = tia_pkg::ER_NOT_INT;
        else begin
          rt = tia_pkg::TY_INT;
          case (tia_pkg::func_t'(item.func))
            tia_pkg::FN_AND: val = a & b;
            tia_pkg::FN_OR:  val = a | b;
            default:         val = a ^ b;
          endcase
        end
      end
      tia_pkg::FN_CAST: begin
        val = (item.target_type == item.left_type) ? a : tia_pkg::read_as(a, item.target_type);
        rt = item.target_type;
      end
      default: ;
    endcase
    ctl.valid = item_valid;
    ctl.is_div = is_dv;
    ctl.is_mod = is_md;
    ctl.neg_q = a[31] ^ b[31];
    ctl.neg_r = a[31];
    ctl.short_res = pt == tia_pkg::TY_SHORT;
    ctl.value = val;
    ctl.rtype = rt;
    ctl.err = err;
    mag_a = ua;
    mag_b = ub;
  end
endmodule

// File: rtl/tia_div_cell.sv
// one restoring-division cell: settles one quotient bit, hands on to the next
module tia_div_cell #(
  parameter int unsigned W = tia_pkg::DataW
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          adv,
  input  tia_pkg::ctl_t ctl_in,
  input  logic [W-1:0]  rem_in,
  input  logic [W-1:0]  quo_in,   // dividend bits shift out as quotient bits shift in
  input  logic [W-1:0]  dsr_in,
  output tia_pkg::ctl_t ctl_out,
  output logic [W-1:0]  rem_out,
  output logic [W-1:0]  quo_out,
  output logic [W-1:0]  dsr_out
);
  logic [W:0] trial, diff;
  logic [W-1:0] rem_nxt;
  logic ge;
  tia_pkg::ctl_t ctl_r;
  logic [W-1:0] rem_r, quo_r, dsr_r;

  always_comb begin
    trial = {rem_in, quo_in[W-1]};
    diff = trial - {1'b0, dsr_in};
    ge = !diff[W];
    rem_nxt = ge ? diff[W-1:0] : trial[W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.valid <= 1'b0;
    end else if (adv) begin
      ctl_r.valid <= ctl_in.valid;
    end
    if (adv) begin
      ctl_r.is_div <= ctl_in.is_div;
      ctl_r.is_mod <= ctl_in.is_mod;
      ctl_r.neg_q <= ctl_in.neg_q;
      ctl_r.neg_r <= ctl_in.neg_r;
      ctl_r.short_res <= ctl_in.short_res;
      ctl_r.value <= ctl_in.value;
      ctl_r.rtype <= ctl_in.rtype;
      ctl_r.err <= ctl_in.err;
      rem_r <= rem_nxt;
      quo_r <= {quo_in[W-2:0], ge};
      dsr_r <= dsr_in;
    end
  end

  assign ctl_out = ctl_r;
  assign rem_out = rem_r;
  assign quo_out = quo_r;
  assign dsr_out = dsr_r;
endmodule
